// ===== design/fan_pkg.sv =====
// Shared types and constants of the frame accumulate and normalize block.
package fan_pkg;

  localparam int NUM_CH     = 4;
  localparam int CFG_W      = 9;
  localparam int NPIX_W     = 18;
  localparam int ADDR_IN_W  = 16;
  localparam int NORM_W     = 8;
  localparam int STAT_W     = 32;

  localparam logic [2:0] MODE_CLEAR = 3'd0;
  localparam logic [2:0] MODE_ACC   = 3'd1;
  localparam logic [2:0] MODE_MEAS  = 3'd2;
  localparam logic [2:0] MODE_SET   = 3'd3;
  localparam logic [2:0] MODE_READ  = 3'd4;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic [1:0] CH_LAST = 2'd3;

  typedef struct packed {
    logic       load_item;
    logic       clr_start;
    logic       clr_step;
    logic       rd_issue;
    logic       acc_write;
    logic       walk_start;
    logic       walk_issue;
    logic       walk_update;
    logic       set_range;
    logic       div_prep;
    logic       div_load;
    logic       div_step;
    logic       emit;
    logic       emit_meas;
    logic       emit_last;
    logic [1:0] chan;
  } fan_cmd_t;

  typedef struct packed {
    logic in_frame;
    logic clr_last;
    logic walk_done;
    logic div_last;
    logic out_free;
  } fan_stat_t;

endpackage

// ===== design/fan_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fan_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 65536,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/fan_ctrl.sv =====
// Controller state machine: sequences clear, accumulate, measure, set and read.
module fan_ctrl
  import fan_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic [2:0] mode_i,
  output logic      in_ready_o,
  input  fan_stat_t stat_i,
  output fan_cmd_t  cmd_o
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CLR   = 4'd2;
  localparam logic [3:0] S_ACC   = 4'd3;
  localparam logic [3:0] S_ACC_W = 4'd4;
  localparam logic [3:0] S_WALK  = 4'd5;
  localparam logic [3:0] S_MOUT  = 4'd6;
  localparam logic [3:0] S_SET   = 4'd7;
  localparam logic [3:0] S_RD    = 4'd8;
  localparam logic [3:0] S_DPREP = 4'd9;
  localparam logic [3:0] S_DLOAD = 4'd10;
  localparam logic [3:0] S_DSTEP = 4'd11;
  localparam logic [3:0] S_EMIT  = 4'd12;

  logic [3:0] state_q, state_d;
  logic [1:0] ch_q, ch_d;
  logic       pend_q, pend_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    ch_d    = ch_q;
    pend_d  = 1'b0;
    cmd_o.chan = ch_q;
    unique case (state_q)
      S_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          unique case (mode_i)
            MODE_CLEAR: begin
              cmd_o.clr_start = 1'b1;
              state_d = S_CLR;
            end
            MODE_ACC:  state_d = S_ACC;
            MODE_MEAS: begin
              cmd_o.walk_start = 1'b1;
              state_d = S_WALK;
            end
            MODE_SET:  state_d = S_SET;
            MODE_READ: state_d = S_RD;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = S_EMIT;
      end
      S_ACC: begin
        if (stat_i.in_frame) begin
          cmd_o.rd_issue = 1'b1;
          state_d = S_ACC_W;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_ACC_W: begin
        cmd_o.acc_write = 1'b1;
        state_d = S_EMIT;
      end
      S_WALK: begin
        if (!stat_i.walk_done) begin
          cmd_o.walk_issue = 1'b1;
          pend_d = 1'b1;
        end
        if (pend_q) cmd_o.walk_update = 1'b1;
        if (stat_i.walk_done && !pend_q) begin
          ch_d = '0;
          state_d = S_MOUT;
        end
      end
      S_MOUT: begin
        if (stat_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_meas = 1'b1;
          cmd_o.emit_last = (ch_q == CH_LAST);
          if (ch_q == CH_LAST) state_d = S_IDLE;
          else ch_d = ch_q + 2'd1;
        end
      end
      S_SET: begin
        cmd_o.set_range = 1'b1;
        state_d = S_EMIT;
      end
      S_RD: begin
        ch_d = '0;
        if (stat_i.in_frame) begin
          cmd_o.rd_issue = 1'b1;
          state_d = S_DPREP;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_DPREP: begin
        cmd_o.div_prep = 1'b1;
        state_d = S_DLOAD;
      end
      S_DLOAD: begin
        cmd_o.div_load = 1'b1;
        state_d = S_DSTEP;
      end
      S_DSTEP: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          if (ch_q == CH_LAST) begin
            state_d = S_EMIT;
          end else begin
            ch_d = ch_q + 2'd1;
            state_d = S_DPREP;
          end
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      ch_q    <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      pend_q  <= pend_d;
    end
  end

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> stat_i.out_free)
    else $error("result issued while output register busy");

  a_read_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_issue |-> stat_i.in_frame)
    else $error("store read outside frame");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.walk_issue |-> !stat_i.walk_done)
    else $error("measure walk past frame end");

  a_item_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (mode_i == MODE_ACC || mode_i == MODE_READ))
      |=> (state_q == S_ACC || state_q == S_RD))
    else $error("accepted item did not start");

endmodule

// ===== design/fan_dp.sv =====
// Datapath: sum store, channel ranges, serial divider and output register.
module fan_dp
  import fan_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int SUM_BITS   = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fan_cmd_t             cmd_i,
  output fan_stat_t            stat_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [2:0]           mode_i,
  input  logic [ADDR_IN_W-1:0] pixel_addr_i,
  input  logic [7:0]           pixel_b_i,
  input  logic [7:0]           pixel_g_i,
  input  logic [7:0]           pixel_r_i,
  input  logic [7:0]           pixel_a_i,
  input  logic [1:0]           range_channel_i,
  input  logic [STAT_W-1:0]    range_low_in_i,
  input  logic [STAT_W-1:0]    range_high_in_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [NORM_W-1:0]    norm_b_o,
  output logic [NORM_W-1:0]    norm_g_o,
  output logic [NORM_W-1:0]    norm_r_o,
  output logic [NORM_W-1:0]    norm_a_o,
  output logic [1:0]           stat_channel_o,
  output logic [STAT_W-1:0]    stat_low_o,
  output logic [STAT_W-1:0]    stat_high_o,
  output logic                 status_o,
  output logic                 last_o
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = ADDR_W + 1;
  localparam int CMP_W  = (CNT_W > NPIX_W) ? CNT_W : NPIX_W;
  localparam int ROW_W  = NUM_CH * SUM_BITS;
  localparam int REM_W  = SUM_BITS + 8;
  localparam logic [12:0] MAX_W13 = 13'(MAX_WIDTH);
  localparam logic [12:0] MAX_H13 = 13'(MAX_HEIGHT);
  localparam logic [SUM_BITS-1:0] SUM_ONES = '1;

  // configuration and frame size
  logic [CFG_W-1:0]  width_q, height_q;
  logic [CFG_W-1:0]  w_eff, h_eff;
  logic [NPIX_W-1:0] npix_q;

  always_comb begin
    w_eff = ({4'b0, width_q} > MAX_W13) ? CFG_W'(MAX_WIDTH) : width_q;
    h_eff = ({4'b0, height_q} > MAX_H13) ? CFG_W'(MAX_HEIGHT) : height_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(256);
      height_q <= CFG_W'(256);
      npix_q   <= NPIX_W'(65536);
    end else begin
      if (cfg_we_i && cfg_index_i == CFG_IDX_WIDTH)  width_q  <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == CFG_IDX_HEIGHT) height_q <= cfg_data_i;
      npix_q <= NPIX_W'(w_eff) * NPIX_W'(h_eff);
    end
  end

  // item registers
  logic [2:0]           mode_q;
  logic [ADDR_IN_W-1:0] addr_q;
  logic [7:0]           byte_q [NUM_CH];
  logic [1:0]           rch_q;
  logic [SUM_BITS-1:0]  rlo_q, rhi_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mode_q    <= mode_i;
      addr_q    <= pixel_addr_i;
      byte_q[0] <= pixel_b_i;
      byte_q[1] <= pixel_g_i;
      byte_q[2] <= pixel_r_i;
      byte_q[3] <= pixel_a_i;
      rch_q     <= range_channel_i;
      rlo_q     <= range_low_in_i[SUM_BITS-1:0];
      rhi_q     <= range_high_in_i[SUM_BITS-1:0];
    end
  end

  logic                    in_frame;
  logic [ADDR_W+ADDR_IN_W-1:0] addr_ext;
  logic [ADDR_W-1:0]       row_addr;

  assign in_frame = {2'b0, addr_q} < npix_q;
  assign addr_ext = (ADDR_W + ADDR_IN_W)'(addr_q);
  assign row_addr = addr_ext[ADDR_W-1:0];

  // sweep and walk counter
  logic [CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.clr_start || cmd_i.walk_start) begin
      cnt_q <= '0;
    end else if (cmd_i.clr_step || cmd_i.walk_issue) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  // sum store
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [ROW_W-1:0]   ram_wdata, ram_rdata, acc_row;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      acc_row[c*SUM_BITS +: SUM_BITS] =
        ram_rdata[c*SUM_BITS +: SUM_BITS] + SUM_BITS'(byte_q[c]);
    end
  end

  assign ram_we    = cmd_i.clr_step || cmd_i.acc_write;
  assign ram_waddr = cmd_i.clr_step ? cnt_q[ADDR_W-1:0] : row_addr;
  assign ram_wdata = cmd_i.clr_step ? '0 : acc_row;
  assign ram_re    = cmd_i.rd_issue || cmd_i.walk_issue;
  assign ram_raddr = cmd_i.walk_issue ? cnt_q[ADDR_W-1:0] : row_addr;

  fan_ram #(.WIDTH(ROW_W), .DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // channel ranges
  logic [SUM_BITS-1:0] lo_q [NUM_CH];
  logic [SUM_BITS-1:0] hi_q [NUM_CH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CH; c++) begin
        lo_q[c] <= SUM_ONES;
        hi_q[c] <= '0;
      end
    end else begin
      for (int c = 0; c < NUM_CH; c++) begin
        if (cmd_i.walk_start) begin
          lo_q[c] <= SUM_ONES;
          hi_q[c] <= '0;
        end else if (cmd_i.walk_update) begin
          if (ram_rdata[c*SUM_BITS +: SUM_BITS] < lo_q[c])
            lo_q[c] <= ram_rdata[c*SUM_BITS +: SUM_BITS];
          if (ram_rdata[c*SUM_BITS +: SUM_BITS] > hi_q[c])
            hi_q[c] <= ram_rdata[c*SUM_BITS +: SUM_BITS];
        end else if (cmd_i.set_range && rch_q == 2'(c)) begin
          lo_q[c] <= rlo_q;
          hi_q[c] <= rhi_q;
        end
      end
    end
  end

  // serial divider: 8 quotient bits, one per cycle
  logic [SUM_BITS-1:0] sel_lo, sel_hi, sel_n, n_clamp;
  logic [SUM_BITS-1:0] diff_q, den_q;
  logic                full_q;
  logic [REM_W-1:0]    rem_q, den_sh;
  logic [REM_W:0]      trial;
  logic [2:0]          k_q;
  logic [NORM_W-1:0]   quo_q, quo_next;
  logic [NORM_W-1:0]   norm_q [NUM_CH];

  always_comb begin
    sel_lo  = lo_q[cmd_i.chan];
    sel_hi  = hi_q[cmd_i.chan];
    sel_n   = ram_rdata[cmd_i.chan*SUM_BITS +: SUM_BITS];
    n_clamp = (sel_n < sel_lo) ? sel_lo : ((sel_n > sel_hi) ? sel_hi : sel_n);
    den_sh  = REM_W'(den_q) << k_q;
    trial   = {1'b0, rem_q} - {1'b0, den_sh};
    quo_next = quo_q;
    if (!trial[REM_W]) quo_next = quo_q | (NORM_W'(1) << k_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_prep) begin
      diff_q <= n_clamp - sel_lo;
      den_q  <= sel_hi - sel_lo;
      full_q <= (sel_lo >= sel_hi);
    end
    if (cmd_i.div_load) begin
      rem_q <= {diff_q, 8'b0} - REM_W'(diff_q);
      quo_q <= '0;
      k_q   <= 3'd7;
    end else if (cmd_i.div_step) begin
      if (!trial[REM_W]) rem_q <= trial[REM_W-1:0];
      quo_q <= quo_next;
      k_q   <= k_q - 3'd1;
      if (k_q == 3'd0) norm_q[cmd_i.chan] <= full_q ? 8'hFF : quo_next;
    end
  end

  // output register
  logic                out_valid_q;
  logic [NORM_W-1:0]   on_q [NUM_CH];
  logic [1:0]          och_q;
  logic [STAT_W-1:0]   olo_q, ohi_q;
  logic                ost_q, olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      for (int c = 0; c < NUM_CH; c++) on_q[c] <= '0;
      och_q   <= '0;
      olo_q   <= '0;
      ohi_q   <= '0;
      ost_q   <= 1'b0;
      olast_q <= cmd_i.emit_last;
      if (cmd_i.emit_meas) begin
        och_q <= cmd_i.chan;
        olo_q <= STAT_W'(sel_lo);
        ohi_q <= STAT_W'(sel_hi);
      end else begin
        unique case (mode_q)
          MODE_SET: begin
            och_q <= rch_q;
            olo_q <= STAT_W'(rlo_q);
            ohi_q <= STAT_W'(rhi_q);
          end
          MODE_ACC: ost_q <= !in_frame;
          MODE_READ: begin
            ost_q <= !in_frame;
            if (in_frame) begin
              for (int c = 0; c < NUM_CH; c++) on_q[c] <= norm_q[c];
            end
          end
          default: ost_q <= 1'b0;
        endcase
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign norm_b_o       = on_q[0];
  assign norm_g_o       = on_q[1];
  assign norm_r_o       = on_q[2];
  assign norm_a_o       = on_q[3];
  assign stat_channel_o = och_q;
  assign stat_low_o     = olo_q;
  assign stat_high_o    = ohi_q;
  assign status_o       = ost_q;
  assign last_o         = olast_q;

  // status to controller
  assign stat_o.in_frame  = in_frame;
  assign stat_o.clr_last  = (cnt_q == CNT_W'(DEPTH - 1));
  assign stat_o.walk_done = (CMP_W'(cnt_q) == CMP_W'(npix_q));
  assign stat_o.div_last  = (k_q == 3'd0);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// ===== design/frame_accumulate_normalize.sv =====
// Top level of the frame accumulate and normalize engine.
//
// Usage: items arrive on the input channel (valid/ready) with a mode field:
// clear, accumulate, measure, set range or read normalized. Each item gives
// one result transaction on the output channel (measure gives four, one per
// channel B, G, R, A, with last on the fourth); undefined modes give none.
// The store holds four sums per pixel in one wide RAM row, so a pixel is a
// single RAM access. Per item, an accumulate reads the row, writes it back
//   and emits; a set range stores the range and emits; a read fetches the
//   row and, for each of the four channels, prepares, loads and runs eight
//   one-bit divide steps; a measure walks the frame one row per cycle; a
//   clear sweeps the whole store one row per cycle.
// Items are taken one at a time; ready is high only while the engine idles.
// After reset the store is swept to zero, one row per cycle, before the
// first item is taken; configuration writes are taken at any time. A
// stalled receiver holds the result in the output register; the engine
// waits there and resumes on acceptance.
module frame_accumulate_normalize
  import fan_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int SUM_BITS   = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // input item
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           mode_i,
  input  logic [ADDR_IN_W-1:0] pixel_addr_i,
  input  logic [7:0]           pixel_b_i,
  input  logic [7:0]           pixel_g_i,
  input  logic [7:0]           pixel_r_i,
  input  logic [7:0]           pixel_a_i,
  input  logic [1:0]           range_channel_i,
  input  logic [STAT_W-1:0]    range_low_in_i,
  input  logic [STAT_W-1:0]    range_high_in_i,
  // result
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [NORM_W-1:0]    norm_b_o,
  output logic [NORM_W-1:0]    norm_g_o,
  output logic [NORM_W-1:0]    norm_r_o,
  output logic [NORM_W-1:0]    norm_a_o,
  output logic [1:0]           stat_channel_o,
  output logic [STAT_W-1:0]    stat_low_o,
  output logic [STAT_W-1:0]    stat_high_o,
  output logic                 status_o,
  output logic                 last_o
);

  // commands flow controller -> datapath, status flows back
  fan_cmd_t  cmd;
  fan_stat_t stat;

  fan_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fan_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .SUM_BITS   (SUM_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .mode_i          (mode_i),
    .pixel_addr_i    (pixel_addr_i),
    .pixel_b_i       (pixel_b_i),
    .pixel_g_i       (pixel_g_i),
    .pixel_r_i       (pixel_r_i),
    .pixel_a_i       (pixel_a_i),
    .range_channel_i (range_channel_i),
    .range_low_in_i  (range_low_in_i),
    .range_high_in_i (range_high_in_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .norm_b_o        (norm_b_o),
    .norm_g_o        (norm_g_o),
    .norm_r_o        (norm_r_o),
    .norm_a_o        (norm_a_o),
    .stat_channel_o  (stat_channel_o),
    .stat_low_o      (stat_low_o),
    .stat_high_o     (stat_high_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the frame accumulate and normalize engine.
`timescale 1ns / 1ps

module testbench;
  import fan_pkg::*;

  localparam int          FRAME_MAX     = 256;
  localparam int          STORE_PIX     = FRAME_MAX * FRAME_MAX;
  localparam logic [2:0]  MODE_SPARE    = 3'd5;  // first undefined mode code
  localparam int          SETTLE_CYCLES = 40;
  localparam int          CYCLE_LIMIT   = 4_000_000;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          REPORT_MAX    = 10;

  typedef struct {
    logic [2:0]  mode;
    logic [15:0] addr;
    logic [7:0]  pix [4];
    logic [1:0]  chan;
    logic [31:0] lo;
    logic [31:0] hi;
  } pixel_item_t;

  typedef struct {
    logic [7:0]  norm [4];
    logic [1:0]  chan;
    logic [31:0] lo;
    logic [31:0] hi;
    logic        status;
    logic        last;
  } pixel_result_t;

  // Keep a private copy of the store, the ranges and the frame size; predict
  // each accepted transaction and check results in order.
  class exposure_scoreboard;
    bit [31:0]     sums [STORE_PIX][4];
    bit [31:0]     chan_lo [4];
    bit [31:0]     chan_hi [4];
    int unsigned   width_reg, height_reg;
    pixel_result_t expected_q [$];
    int            n_checked, n_bad;

    function new();
      for (int c = 0; c < 4; c++) begin
        chan_lo[c] = '1;
        chan_hi[c] = '0;
      end
      width_reg  = 256;
      height_reg = 256;
    endfunction

    function void set_frame(logic idx, logic [8:0] val);
      if (idx == CFG_IDX_WIDTH) width_reg = val;
      else height_reg = val;
    endfunction

    function int unsigned pixels();
      int unsigned w, h;
      w = (width_reg > FRAME_MAX) ? FRAME_MAX : width_reg;
      h = (height_reg > FRAME_MAX) ? FRAME_MAX : height_reg;
      return w * h;
    endfunction

    function bit [7:0] stretch(bit [31:0] n, bit [31:0] lo, bit [31:0] hi);
      bit [39:0] prod;
      bit [31:0] v;
      if (lo >= hi) return 8'hFF;
      v = n;
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      prod = 40'(v - lo) * 40'd255;
      return 8'(prod / 40'(hi - lo));
    endfunction

    function pixel_result_t blank();
      pixel_result_t r;
      foreach (r.norm[c]) r.norm[c] = '0;
      r.chan = '0; r.lo = '0; r.hi = '0; r.status = 1'b0; r.last = 1'b1;
      return r;
    endfunction

    function void note_item(pixel_item_t it);
      pixel_result_t r;
      int unsigned   npix;
      bit            in_frame;
      npix     = pixels();
      in_frame = it.addr < npix;
      r        = blank();
      case (it.mode)
        MODE_CLEAR: begin
          for (int p = 0; p < STORE_PIX; p++)
            for (int c = 0; c < 4; c++) sums[p][c] = '0;
          expected_q.push_back(r);
        end
        MODE_ACC: begin
          if (in_frame) begin
            for (int c = 0; c < 4; c++) sums[it.addr][c] += it.pix[c];
          end else begin
            r.status = 1'b1;
          end
          expected_q.push_back(r);
        end
        MODE_MEAS: begin
          for (int c = 0; c < 4; c++) begin
            chan_lo[c] = '1;
            chan_hi[c] = '0;
          end
          for (int p = 0; p < npix; p++)
            for (int c = 0; c < 4; c++) begin
              if (sums[p][c] < chan_lo[c]) chan_lo[c] = sums[p][c];
              if (sums[p][c] > chan_hi[c]) chan_hi[c] = sums[p][c];
            end
          for (int c = 0; c < 4; c++) begin
            r      = blank();
            r.chan = 2'(c);
            r.lo   = chan_lo[c];
            r.hi   = chan_hi[c];
            r.last = (2'(c) == CH_LAST);
            expected_q.push_back(r);
          end
        end
        MODE_SET: begin
          chan_lo[it.chan] = it.lo;
          chan_hi[it.chan] = it.hi;
          r.chan = it.chan;
          r.lo   = it.lo;
          r.hi   = it.hi;
          expected_q.push_back(r);
        end
        MODE_READ: begin
          if (in_frame) begin
            for (int c = 0; c < 4; c++)
              r.norm[c] = stretch(sums[it.addr][c], chan_lo[c], chan_hi[c]);
          end else begin
            r.status = 1'b1;
          end
          expected_q.push_back(r);
        end
        default: ;  // undefined modes produce nothing
      endcase
    endfunction

    function void check_result(pixel_result_t got);
      pixel_result_t want;
      bit            bad;
      n_checked++;
      if (expected_q.size() == 0) begin
        n_bad++;
        if (n_bad <= REPORT_MAX)
          $display("ERROR: unexpected result ch=%0d lo=%h hi=%h st=%b last=%b",
                   got.chan, got.lo, got.hi, got.status, got.last);
        return;
      end
      want = expected_q.pop_front();
      bad  = 1'b0;
      for (int c = 0; c < 4; c++) if (got.norm[c] !== want.norm[c]) bad = 1'b1;
      if (got.chan !== want.chan) bad = 1'b1;
      if (got.lo !== want.lo) bad = 1'b1;
      if (got.hi !== want.hi) bad = 1'b1;
      if (got.status !== want.status) bad = 1'b1;
      if (got.last !== want.last) bad = 1'b1;
      if (bad) begin
        n_bad++;
        if (n_bad <= REPORT_MAX) begin
          $display("ERROR: result %0d mismatch", n_checked);
          $display("  expected norm=%h %h %h %h ch=%0d lo=%h hi=%h st=%b last=%b",
                   want.norm[0], want.norm[1], want.norm[2], want.norm[3],
                   want.chan, want.lo, want.hi, want.status, want.last);
          $display("  actual   norm=%h %h %h %h ch=%0d lo=%h hi=%h st=%b last=%b",
                   got.norm[0], got.norm[1], got.norm[2], got.norm[3],
                   got.chan, got.lo, got.hi, got.status, got.last);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [8:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  mode_i = '0;
  logic [15:0] pixel_addr_i = '0;
  logic [7:0]  pixel_b_i = '0, pixel_g_i = '0, pixel_r_i = '0, pixel_a_i = '0;
  logic [1:0]  range_channel_i = '0;
  logic [31:0] range_low_in_i = '0, range_high_in_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  norm_b_o, norm_g_o, norm_r_o, norm_a_o;
  logic [1:0]  stat_channel_o;
  logic [31:0] stat_low_o, stat_high_o;
  logic        status_o, last_o;

  frame_accumulate_normalize DUT (.*);

  exposure_scoreboard sb = new();

  // Stimulus-side view of the frame, kept next to the scoreboard's own copy.
  int unsigned cur_w = 256, cur_h = 256;
  bit          calm = 1'b0;      // no idling on either side
  bit          hold_off = 1'b0;  // receiver pressure window
  int          accepted = 0;
  int          mode_count [8];
  int          settings_run = 1;
  int unsigned cycles = 0;

  always #2 clk_i = ~clk_i;

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sample each result transaction at the rising edge and check it.
  always @(posedge clk_i) begin
    pixel_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.norm[0] = norm_b_o;
      got.norm[1] = norm_g_o;
      got.norm[2] = norm_r_o;
      got.norm[3] = norm_a_o;
      got.chan    = stat_channel_o;
      got.lo      = stat_low_o;
      got.hi      = stat_high_o;
      got.status  = status_o;
      got.last    = last_o;
      sb.check_result(got);
    end
  end

  // Receiver: alternate ready bursts and stall bursts; hold low during the
  // pressure window, stay ready once the run goes calm.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ready_i = 1'b0;
      end else if (calm || $urandom_range(0, 3) != 0) begin
        out_ready_i = 1'b1;
        repeat ($urandom_range(1, 20) - 1) begin
          @(negedge clk_i);
          if (hold_off) break;
        end
        if (hold_off) out_ready_i = 1'b0;
      end else begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk_i);
      end
    end
  end

  // Pressure: stall the output long enough that the engine backs up and
  // drops input ready while items keep coming.
  initial begin
    wait (accepted >= 120);
    @(negedge clk_i);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
  end

  function automatic pixel_item_t mk_item(logic [2:0] mode, logic [15:0] addr,
                                          logic [31:0] bgra, logic [1:0] chan,
                                          logic [31:0] lo, logic [31:0] hi);
    pixel_item_t it;
    it.mode   = mode;
    it.addr   = addr;
    it.pix[0] = bgra[31:24];
    it.pix[1] = bgra[23:16];
    it.pix[2] = bgra[15:8];
    it.pix[3] = bgra[7:0];
    it.chan   = chan;
    it.lo     = lo;
    it.hi     = hi;
    return it;
  endfunction

  // Offer one transaction, with an optional idle burst first; return on
  // acceptance, aligned to the next falling edge.
  task automatic send_item(pixel_item_t it);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    mode_i          = it.mode;
    pixel_addr_i    = it.addr;
    pixel_b_i       = it.pix[0];
    pixel_g_i       = it.pix[1];
    pixel_r_i       = it.pix[2];
    pixel_a_i       = it.pix[3];
    range_channel_i = it.chan;
    range_low_in_i  = it.lo;
    range_high_in_i = it.hi;
    in_valid_i      = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(it);
    accepted++;
    mode_count[it.mode]++;
    @(negedge clk_i);
  endtask

  // Wait for every expected result, then let a trailing item settle.
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_frame(int unsigned w, int unsigned h);
    cfg_we_i    = 1'b1;
    cfg_index_i = CFG_IDX_WIDTH;
    cfg_data_i  = w[8:0];
    @(negedge clk_i);
    cfg_index_i = CFG_IDX_HEIGHT;
    cfg_data_i  = h[8:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_frame(CFG_IDX_WIDTH, w[8:0]);
    sb.set_frame(CFG_IDX_HEIGHT, h[8:0]);
    cur_w = w;
    cur_h = h;
    settings_run++;
  endtask

  // Draw one random transaction; mostly accumulate and read inside the frame.
  task automatic random_item(output pixel_item_t it, input bit allow_meas,
                             inout int clear_budget);
    int unsigned npix, pick;
    logic [15:0] addr;
    npix = ((cur_w > FRAME_MAX) ? FRAME_MAX : cur_w) *
           ((cur_h > FRAME_MAX) ? FRAME_MAX : cur_h);
    if (npix > 0 && $urandom_range(0, 99) < 85) addr = 16'($urandom_range(0, npix - 1));
    else addr = 16'($urandom);
    it = mk_item(MODE_ACC, addr, $urandom, 2'($urandom_range(0, 3)), $urandom, $urandom);
    if ($urandom_range(0, 1) == 1) begin
      // small ranges near the sums give varied stretch values
      it.lo = $urandom_range(0, 600);
      it.hi = $urandom_range(0, 2000);
    end
    pick = $urandom_range(0, 99);
    if (pick < 45) it.mode = MODE_ACC;
    else if (pick < 75) it.mode = MODE_READ;
    else if (pick < 86) it.mode = MODE_SET;
    else if (pick < 93 && allow_meas) it.mode = MODE_MEAS;
    else if (pick < 96) it.mode = MODE_SPARE + 3'($urandom_range(0, 2));
    else if (clear_budget > 0 && pick == 99) begin
      it.mode = MODE_CLEAR;
      clear_budget--;
    end else it.mode = MODE_READ;
  endtask

  initial begin
    int unsigned widths  [8] = '{1, 3, 256, 0, 511, 16, 7, 256};
    int unsigned heights [8] = '{1, 5, 1, 4, 2, 16, 300, 256};
    pixel_item_t it;
    int          clear_budget;
    int          n;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset ranges, byte extremes at both ends of the full frame,
    // degenerate and inverted ranges, undefined modes, clear.
    send_item(mk_item(MODE_READ, 16'd0, '0, 2'd0, '0, '0));
    send_item(mk_item(MODE_ACC, 16'd0, 32'hFFFF_FFFF, 2'd0, '1, '1));
    send_item(mk_item(MODE_ACC, 16'hFFFF, 32'h00FF_00FF, 2'd3, '0, '1));
    send_item(mk_item(MODE_ACC, 16'd0, 32'h8001_FE7F, 2'd1, '0, '0));
    send_item(mk_item(MODE_MEAS, 16'hFFFF, '1, 2'd2, '1, '0));
    send_item(mk_item(MODE_READ, 16'd0, '0, 2'd0, '0, '0));
    send_item(mk_item(MODE_READ, 16'hFFFF, '0, 2'd0, '0, '0));
    send_item(mk_item(MODE_READ, 16'd1, '0, 2'd0, '0, '0));
    send_item(mk_item(MODE_SET, 16'd0, '0, 2'd0, 32'd0, 32'hFFFF_FFFF));
    send_item(mk_item(MODE_SET, 16'd0, '0, 2'd1, 32'd5, 32'd5));
    send_item(mk_item(MODE_SET, 16'd0, '0, 2'd2, 32'hFFFF_FFFF, 32'd0));
    send_item(mk_item(MODE_SET, 16'd0, '0, CH_LAST, 32'd100, 32'd200));
    send_item(mk_item(MODE_READ, 16'd0, '0, 2'd0, '0, '0));
    send_item(mk_item(MODE_SPARE, 16'd0, '1, 2'd0, '0, '0));
    send_item(mk_item(MODE_SPARE + 3'd1, 16'd0, '1, 2'd0, '0, '0));
    send_item(mk_item(MODE_SPARE + 3'd2, 16'd0, '1, 2'd0, '0, '0));
    send_item(mk_item(MODE_SET, 16'd0, '0, CH_LAST, 32'd0, 32'd1));
    send_item(mk_item(MODE_READ, 16'hFFFF, '0, 2'd0, '0, '0));
    send_item(mk_item(MODE_READ, 16'h7FFF, '0, 2'd0, '0, '0));
    send_item(mk_item(MODE_CLEAR, 16'd0, '0, 2'd0, '0, '0));
    send_item(mk_item(MODE_READ, 16'd0, '0, 2'd0, '0, '0));
    drain();

    // Random phases across frame settings, the extremes among them; the
    // last phase runs calm at the full frame.
    clear_budget = 1;
    for (int ph = 0; ph < 8; ph++) begin
      write_frame(widths[ph], heights[ph]);
      calm = (ph == 7);
      n = 0;
      while (n < 42) begin
        random_item(it, (ph != 7), clear_budget);
        send_item(it);
        if (it.mode <= MODE_READ) n++;
      end
      drain();
    end

    $display("Covered %0d transactions over %0d frame settings: %0d clear, %0d acc,",
             accepted, settings_run, mode_count[MODE_CLEAR], mode_count[MODE_ACC]);
    $display("  %0d measure, %0d set range, %0d read; %0d results checked.",
             mode_count[MODE_MEAS], mode_count[MODE_SET], mode_count[MODE_READ],
             sb.n_checked);
    if (sb.n_bad == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", sb.n_bad);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
